/* hdl/pps_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by pps_cell and preemptive_priority_schedule_top.
package pps_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int MAX_PROCS_HI  = 64;

   localparam int ARR_W    = 16;
   localparam int BURST_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int AB_W     = ARR_W + 1;      // arrival plus burst
   localparam int IDX_W    = $clog2(MAX_PROCS_HI);
   localparam int PIDX_W   = 5;
   localparam int TOUT_W   = 21;
   localparam int SUM_W    = 25;

   // best candidate and earliest pending arrival, swept along the cell row
   typedef struct packed {
      logic               valid;
      logic [PRIO_W-1:0]  prio;
      logic [IDX_W-1:0]   idx;
      logic [BURST_W-1:0] rem;
      logic               nxt_valid;
      logic [ARR_W-1:0]   nxt_arr;
   } token_type;

   // service granted to one cell at the end of a sweep
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [BURST_W-1:0] slice;
   } apply_type;

endpackage

/* hdl/pps_cell.sv */
// One process slot of the scheduler row: descriptor storage, sweep stage
// and output shift stage. Depends on pps_pkg.
module pps_cell import pps_pkg::*; #(
   parameter int INDEX  = 0,
   parameter int TIME_W = 21
) (
   input  logic               clock,
   input  logic               load_en,
   input  logic               clear_en,
   input  logic [ARR_W-1:0]   load_arr,
   input  logic [BURST_W-1:0] load_burst,
   input  logic [PRIO_W-1:0]  load_prio,
   input  logic [TIME_W-1:0]  sim_time,
   input  logic [TIME_W-1:0]  new_time,
   input  token_type          tok_i,
   output token_type          tok_o,
   input  apply_type          apply,
   input  logic               shift_en,
   input  logic [ARR_W-1:0]   nb_arr,
   input  logic [AB_W-1:0]    nb_ab,
   input  logic [TIME_W-1:0]  nb_fin,
   output logic [ARR_W-1:0]   arr,
   output logic [AB_W-1:0]    ab,
   output logic [TIME_W-1:0]  fin
);

   logic [ARR_W-1:0]   arr_ff,  arr_in;
   logic [AB_W-1:0]    ab_ff,   ab_in;
   logic [TIME_W-1:0]  fin_ff,  fin_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [BURST_W-1:0] rem_ff,  rem_in;
   token_type          tok_ff,  tok_in;
   logic               eligible, pending, hit;

   assign hit      = apply.en && (apply.idx == IDX_W'(INDEX));
   assign eligible = (rem_ff != '0) && (TIME_W'(arr_ff) <= sim_time);
   assign pending  = (rem_ff != '0) && (TIME_W'(arr_ff) > sim_time);

   always_comb begin
      arr_in  = arr_ff;
      ab_in   = ab_ff;
      fin_in  = fin_ff;
      prio_in = prio_ff;
      rem_in  = rem_ff;
      if (load_en) begin
         arr_in  = load_arr;
         ab_in   = AB_W'(load_arr) + AB_W'(load_burst);
         prio_in = load_prio;
         rem_in  = load_burst;
         fin_in  = TIME_W'(load_arr);   // zero burst finishes on arrival
      end else if (clear_en) begin
         rem_in = '0;
      end else if (shift_en) begin
         arr_in = nb_arr;
         ab_in  = nb_ab;
         fin_in = nb_fin;
      end else if (hit) begin
         rem_in = rem_ff - apply.slice;
         if (rem_ff == apply.slice) begin
            fin_in = new_time;
         end
      end
   end

   // strict less-than keeps the lower index on a priority tie
   always_comb begin
      tok_in = tok_i;
      if (eligible && (!tok_i.valid || prio_ff < tok_i.prio)) begin
         tok_in.valid = 1'b1;
         tok_in.prio  = prio_ff;
         tok_in.idx   = IDX_W'(INDEX);
         tok_in.rem   = rem_ff;
      end
      if (pending && (!tok_i.nxt_valid || arr_ff < tok_i.nxt_arr)) begin
         tok_in.nxt_valid = 1'b1;
         tok_in.nxt_arr   = arr_ff;
      end
   end

   always_ff @(posedge clock) begin
      arr_ff  <= arr_in;
      ab_ff   <= ab_in;
      fin_ff  <= fin_in;
      prio_ff <= prio_in;
      rem_ff  <= rem_in;
      tok_ff  <= tok_in;
   end

   assign tok_o = tok_ff;
   assign arr   = arr_ff;
   assign ab    = ab_ff;
   assign fin   = fin_ff;

endmodule

/* hdl/preemptive_priority_schedule_top.sv */
// Preemptive priority scheduler top: a row of pps_cell slots, types from pps_pkg.
// Load: one descriptor beat per cycle.
// Schedule: each event (completion or arrival) costs one sweep of the cell
// row; at most 2*MAX_PROCS events plus one closing sweep.
// Results: one beat per cycle while rsp_ready is held high, from an output register.
// Reset clears control state only; remaining bursts in the cells are cleared when slot 0 loads.
module preemptive_priority_schedule_top import pps_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ARR_W-1:0]   req_arrival_time,
   input  logic [BURST_W-1:0] req_burst_time,
   input  logic [PRIO_W-1:0]  req_prio_level,
   input  logic               req_last_process,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIDX_W-1:0]  rsp_process_index,
   output logic [TOUT_W-1:0]  rsp_completion_time,
   output logic [TOUT_W-1:0]  rsp_turnaround_time,
   output logic [TOUT_W-1:0]  rsp_waiting_time,
   output logic [SUM_W-1:0]   rsp_sum_waiting,
   output logic [SUM_W-1:0]   rsp_sum_turnaround,
   output logic               rsp_last_result
);

   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int TIME_W = $clog2((MAX_PROCS + 1) * 65536);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_RUN  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [SUM_W-1:0]   sum_tat_ff, sum_tat_in;
   logic [SUM_W-1:0]   sum_wt_ff, sum_wt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   logic [TOUT_W-1:0]  ct_ff, ct_in;
   logic [TOUT_W-1:0]  tat_ff, tat_in;
   logic [TOUT_W-1:0]  wt_ff, wt_in;
   logic [SUM_W-1:0]   osum_wt_ff, osum_wt_in;
   logic [SUM_W-1:0]   osum_tat_ff, osum_tat_in;
   logic               olast_ff, olast_in;

   token_type          tok_w [MAX_PROCS+1];
   logic [ARR_W-1:0]   arr_w [MAX_PROCS+1];
   logic [AB_W-1:0]    ab_w  [MAX_PROCS+1];
   logic [TIME_W-1:0]  fin_w [MAX_PROCS+1];

   apply_type          apply;
   logic [TIME_W-1:0]  new_time, gap;
   logic [BURST_W-1:0] slice;
   logic               req_fire, last_eff, sweep_done, emit_take, emit_last;
   logic [TIME_W-1:0]  tat_full, wt_full;
   token_type          best;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_fire   = req_valid && req_ready;
   assign last_eff   = req_last_process || (slot_ff == CNT_W'(MAX_PROCS - 1));
   assign sweep_done = (state_ff == ST_RUN) && (cnt_ff == CNT_W'(MAX_PROCS));
   assign best       = tok_w[MAX_PROCS];

   // slice runs to the pick's completion or the next arrival, whichever first
   always_comb begin
      gap = TIME_W'(best.nxt_arr) - time_ff;
      if (!best.nxt_valid || TIME_W'(best.rem) <= gap) begin
         slice = best.rem;
      end else begin
         slice = gap[BURST_W-1:0];
      end
      new_time    = time_ff + TIME_W'(slice);
      apply.en    = sweep_done && best.valid;
      apply.idx   = best.idx;
      apply.slice = slice;
   end

   assign emit_take = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = (k_ff + CNT_W'(1)) == n_ff;
   assign tat_full  = fin_w[0] - TIME_W'(arr_w[0]);
   assign wt_full   = fin_w[0] - TIME_W'(ab_w[0]);

   assign tok_w[0]         = '0;
   assign arr_w[MAX_PROCS] = '0;
   assign ab_w[MAX_PROCS]  = '0;
   assign fin_w[MAX_PROCS] = '0;

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      pps_cell #(
         .INDEX  (i),
         .TIME_W (TIME_W)
      ) u_cell (
         .clock      (clock),
         .load_en    (req_fire && (slot_ff == CNT_W'(i))),
         .clear_en   (req_fire && (slot_ff == '0)),
         .load_arr   (req_arrival_time),
         .load_burst (req_burst_time),
         .load_prio  (req_prio_level),
         .sim_time   (time_ff),
         .new_time   (new_time),
         .tok_i      (tok_w[i]),
         .tok_o      (tok_w[i+1]),
         .apply      (apply),
         .shift_en   (emit_take),
         .nb_arr     (arr_w[i+1]),
         .nb_ab      (ab_w[i+1]),
         .nb_fin     (fin_w[i+1]),
         .arr        (arr_w[i]),
         .ab         (ab_w[i]),
         .fin        (fin_w[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      n_in        = n_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      time_in     = time_ff;
      sum_tat_in  = sum_tat_ff;
      sum_wt_in   = sum_wt_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (last_eff) begin
                  n_in     = slot_ff + CNT_W'(1);
                  slot_in  = '0;
                  cnt_in   = '0;
                  time_in  = '0;
                  state_in = ST_RUN;
               end else begin
                  slot_in = slot_ff + CNT_W'(1);
               end
            end
         end
         ST_RUN: begin
            if (sweep_done) begin
               cnt_in = '0;
               if (best.valid) begin
                  time_in = new_time;
               end else if (best.nxt_valid) begin
                  time_in = TIME_W'(best.nxt_arr);
               end else begin
                  k_in       = '0;
                  sum_tat_in = '0;
                  sum_wt_in  = '0;
                  state_in   = ST_EMIT;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_take) begin
               k_in       = k_ff + CNT_W'(1);
               sum_tat_in = sum_tat_ff + SUM_W'(tat_full);
               sum_wt_in  = sum_wt_ff + SUM_W'(wt_full);
               if (emit_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // output register: the next run may load while the last beat waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pidx_in      = pidx_ff;
      ct_in        = ct_ff;
      tat_in       = tat_ff;
      wt_in        = wt_ff;
      osum_wt_in   = osum_wt_ff;
      osum_tat_in  = osum_tat_ff;
      olast_in     = olast_ff;
      if (emit_take) begin
         rsp_valid_in = 1'b1;
         pidx_in      = PIDX_W'(k_ff + CNT_W'(1));
         ct_in        = TOUT_W'(fin_w[0]);
         tat_in       = TOUT_W'(tat_full);
         wt_in        = TOUT_W'(wt_full);
         osum_wt_in   = emit_last ? sum_wt_in : '0;
         osum_tat_in  = emit_last ? sum_tat_in : '0;
         olast_in     = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         slot_ff      <= '0;
         n_ff         <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_tat_ff  <= sum_tat_in;
      sum_wt_ff   <= sum_wt_in;
      pidx_ff     <= pidx_in;
      ct_ff       <= ct_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      osum_wt_ff  <= osum_wt_in;
      osum_tat_ff <= osum_tat_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_process_index   = pidx_ff;
   assign rsp_completion_time = ct_ff;
   assign rsp_turnaround_time = tat_ff;
   assign rsp_waiting_time    = wt_ff;
   assign rsp_sum_waiting     = osum_wt_ff;
   assign rsp_sum_turnaround  = osum_tat_ff;
   assign rsp_last_result     = olast_ff;

endmodule
